>>> sv/eul_pkg.sv
// ----------------------------------------------------------------------------
// eul_pkg
// shared constants, types and helpers for the euler xyz rotation matrix
// ----------------------------------------------------------------------------
package eul_pkg;

    localparam int ANGLE_BITS        = 16;
    localparam int OUT_FRAC_BITS     = 14;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_STAGES     = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;
    localparam int OUT_WIDTH         = OUT_FRAC_BITS + 2;
    localparam int IN_WIDTH          = 16;
    localparam int Q_WIDTH           = 34;

    localparam logic signed [Q_WIDTH-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    typedef logic signed [Q_WIDTH-1:0] t_q30;

    typedef struct packed {
        t_q30 c;
        t_q30 s;
    } t_sincos;

    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

    // q30 product, rounded half up (floor after adding 2^29)
    function automatic t_q30 qmul(input t_q30 a, input t_q30 b);
        logic signed [2*Q_WIDTH-1:0] p;
        begin
            p = a * b + (68'sd1 <<< 29);
            return t_q30'(p >>> 30);
        end
    endfunction

endpackage

>>> sv/eul_cordic.sv
// ----------------------------------------------------------------------------
// eul_cordic
// pipelined cordic rotator, one stage per iteration, gives cos and sin in q4.30
// ----------------------------------------------------------------------------
module eul_cordic (
    input  logic                           i_clk,
    input  logic [eul_pkg::IN_WIDTH-1:0]   i_angle,
    output eul_pkg::t_sincos               o_sc
);

    localparam int N = eul_pkg::CORDIC_STAGES;

    eul_pkg::t_q30 r_x    [N+1];
    eul_pkg::t_q30 r_y    [N+1];
    logic signed [32:0] r_z [N+1];
    logic          r_flip [N+1];

    logic [eul_pkg::ANGLE_BITS-1:0] w_raw;
    logic [31:0]                    w_phase;
    logic [31:0]                    w_rot;
    logic                           w_flip;

    assign w_raw   = i_angle[eul_pkg::ANGLE_BITS-1:0];
    assign w_phase = 32'(w_raw) << (32 - eul_pkg::ANGLE_BITS);
    assign w_rot   = w_phase + 32'h40000000;
    assign w_flip  = w_rot[31];

    // stage 0: quadrant fold
    always_ff @(posedge i_clk) begin
        r_x[0]    <= eul_pkg::CORDIC_GAIN;
        r_y[0]    <= '0;
        r_z[0]    <= 33'(signed'(w_flip ? (w_phase + 32'h80000000) : w_phase));
        r_flip[0] <= w_flip;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [31:0] w_atan;
        assign w_atan = eul_pkg::atan_turn32(5'(i));
        always_ff @(posedge i_clk) begin
            if (!r_z[i][32]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - signed'({1'b0, w_atan});
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + signed'({1'b0, w_atan});
            end
            r_flip[i+1] <= r_flip[i];
        end
    end

    always_ff @(posedge i_clk) begin
        o_sc.c <= r_flip[N] ? -r_x[N] : r_x[N];
        o_sc.s <= r_flip[N] ? -r_y[N] : r_y[N];
    end

endmodule

>>> sv/eul_matrix.sv
// ----------------------------------------------------------------------------
// eul_matrix
// closed form matrix products, rounding and saturation over four stages
// ----------------------------------------------------------------------------
module eul_matrix (
    input  logic                                   i_clk,
    input  eul_pkg::t_sincos                       i_scx,
    input  eul_pkg::t_sincos                       i_scy,
    input  eul_pkg::t_sincos                       i_scz,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]   o_m [9]
);

    eul_pkg::t_q30 r_cx, r_sx, r_cy, r_sy, r_cz, r_sz, r_sxsy, r_cxsy;
    eul_pkg::t_q30 r_p [14];
    eul_pkg::t_q30 r_s [9];

    // stage a: partial products for the triple terms
    always_ff @(posedge i_clk) begin
        r_cx   <= i_scx.c;
        r_sx   <= i_scx.s;
        r_cy   <= i_scy.c;
        r_sy   <= i_scy.s;
        r_cz   <= i_scz.c;
        r_sz   <= i_scz.s;
        r_sxsy <= eul_pkg::qmul(i_scx.s, i_scy.s);
        r_cxsy <= eul_pkg::qmul(i_scx.c, i_scy.s);
    end

    // stage b: every product
    always_ff @(posedge i_clk) begin
        r_p[0]  <= eul_pkg::qmul(r_cy, r_cz);
        r_p[1]  <= eul_pkg::qmul(r_cy, r_sz);
        r_p[2]  <= r_sy;
        r_p[3]  <= eul_pkg::qmul(r_sxsy, r_cz);
        r_p[4]  <= eul_pkg::qmul(r_cx, r_sz);
        r_p[5]  <= eul_pkg::qmul(r_cx, r_cz);
        r_p[6]  <= eul_pkg::qmul(r_sxsy, r_sz);
        r_p[7]  <= eul_pkg::qmul(r_sx, r_cy);
        r_p[8]  <= eul_pkg::qmul(r_sx, r_sz);
        r_p[9]  <= eul_pkg::qmul(r_cxsy, r_cz);
        r_p[10] <= eul_pkg::qmul(r_cxsy, r_sz);
        r_p[11] <= eul_pkg::qmul(r_sx, r_cz);
        r_p[12] <= eul_pkg::qmul(r_cx, r_cy);
        r_p[13] <= '0;
    end

    // stage c: sums
    always_ff @(posedge i_clk) begin
        r_s[0] <= r_p[0];
        r_s[1] <= -r_p[1];
        r_s[2] <= r_p[2];
        r_s[3] <= r_p[3] + r_p[4];
        r_s[4] <= r_p[5] - r_p[6];
        r_s[5] <= -r_p[7];
        r_s[6] <= r_p[8] - r_p[9];
        r_s[7] <= r_p[10] + r_p[11] + r_p[13];
        r_s[8] <= r_p[12];
    end

    // stage d: round and clamp
    for (genvar k = 0; k < 9; k++) begin : g_out
        eul_pkg::t_q30 w_r;
        always_comb begin
            if (eul_pkg::OUT_FRAC_BITS >= 30) begin
                w_r = r_s[k];
            end else begin
                w_r = (r_s[k] + (eul_pkg::t_q30'(1) <<< (29 - eul_pkg::OUT_FRAC_BITS)))
                      >>> (30 - eul_pkg::OUT_FRAC_BITS);
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_r > (eul_pkg::t_q30'(1) <<< eul_pkg::OUT_FRAC_BITS)) begin
                o_m[k] <= eul_pkg::OUT_WIDTH'(1 << eul_pkg::OUT_FRAC_BITS);
            end else if (w_r < -(eul_pkg::t_q30'(1) <<< eul_pkg::OUT_FRAC_BITS)) begin
                o_m[k] <= eul_pkg::OUT_WIDTH'(-(1 << eul_pkg::OUT_FRAC_BITS));
            end else begin
                o_m[k] <= w_r[eul_pkg::OUT_WIDTH-1:0];
            end
        end
    end

endmodule

>>> sv/euler_xyz_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_xyz_rotation_matrix
// rotation matrix rx*ry*rz from three binary angles
// ----------------------------------------------------------------------------
// usage: drive the three angles with start high for one cycle per item;
// busy never rises, so a new item is taken on every clock edge with start
// high. each angle runs through its own cordic pipeline (one register stage
// per iteration, plus fold and sign stages), then four product, sum and
// rounding stages. throughput is one item per cycle. o_done marks the result
// for exactly one cycle; the receiver cannot stall, so nothing waits. reset
// clears only the valid pipe; the datapath is free running.
// ----------------------------------------------------------------------------
module euler_xyz_rotation_matrix (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [eul_pkg::IN_WIDTH-1:0]   i_angle_x,
    input  logic signed [eul_pkg::IN_WIDTH-1:0]   i_angle_y,
    input  logic signed [eul_pkg::IN_WIDTH-1:0]   i_angle_z,
    output logic                                  o_done,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_m00,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_m01,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_m02,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_m10,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_m11,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_m12,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_m20,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_m21,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_m22
);

    // fold + stages + sign in the cordic, four in the matrix
    localparam int LATENCY = eul_pkg::CORDIC_STAGES + 6;

    eul_pkg::t_sincos w_scx, w_scy, w_scz;
    logic signed [eul_pkg::OUT_WIDTH-1:0] w_m [9];
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;

    // pipeline never holds off
    assign busy = 1'b0;

    eul_cordic u_cx (.i_clk(i_clk), .i_angle(i_angle_x), .o_sc(w_scx));
    eul_cordic u_cy (.i_clk(i_clk), .i_angle(i_angle_y), .o_sc(w_scy));
    eul_cordic u_cz (.i_clk(i_clk), .i_angle(i_angle_z), .o_sc(w_scz));

    eul_matrix u_mat (
        .i_clk(i_clk), .i_scx(w_scx), .i_scy(w_scy), .i_scz(w_scz), .o_m(w_m)
    );

    // valid bit travels alongside the data
    assign n_vld = {r_vld[LATENCY-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_done = r_vld[LATENCY-1];
    assign o_m00  = w_m[0];
    assign o_m01  = w_m[1];
    assign o_m02  = w_m[2];
    assign o_m10  = w_m[3];
    assign o_m11  = w_m[4];
    assign o_m12  = w_m[5];
    assign o_m20  = w_m[6];
    assign o_m21  = w_m[7];
    assign o_m22  = w_m[8];

`ifndef SYNTHESIS
    // a result follows every item after the full latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("item lost in pipeline");

    // entries m02 and m22 stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_m02 <= 16'sd16384 && o_m02 >= -16'sd16384
                    && o_m22 <= 16'sd16384 && o_m22 >= -16'sd16384))
        else $error("entry out of range");
`endif

endmodule
